FILE: design/mdp_pkg.sv
package mdp_pkg;

    // Descriptor characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_Z      = 8'h5A;

    // Dense return type codes
    localparam logic [3:0] TYPE_BYTE    = 4'd0;
    localparam logic [3:0] TYPE_CHAR    = 4'd1;
    localparam logic [3:0] TYPE_DOUBLE  = 4'd2;
    localparam logic [3:0] TYPE_FLOAT   = 4'd3;
    localparam logic [3:0] TYPE_INT     = 4'd4;
    localparam logic [3:0] TYPE_LONG    = 4'd5;
    localparam logic [3:0] TYPE_REF     = 4'd6;
    localparam logic [3:0] TYPE_SHORT   = 4'd7;
    localparam logic [3:0] TYPE_BOOLEAN = 4'd8;
    localparam logic [3:0] TYPE_VOID    = 4'd9;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WARN    = 2'd1;
    localparam logic [1:0] ST_NOCLOSE = 2'd2;
    localparam logic [1:0] ST_UNTERM  = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] ch;
    } mdp_in_t;

    typedef struct packed {
        logic       sig_valid;
        logic [7:0] sig_char;
        logic [7:0] arg_count;
        logic       ret_valid;
        logic [3:0] ret_type;
        logic       done_res;
        logic [1:0] status;
    } mdp_out_t;

    typedef struct packed {
        logic       known;
        logic [3:0] code;
    } ret_decode_t;

    function automatic logic is_prim(input logic [7:0] c);
        return c inside {CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z, CH_V};
    endfunction

    function automatic ret_decode_t decode_type(input logic [7:0] c);
        ret_decode_t r;
        r.known = 1'b1;
        case (c)
            CH_B:           r.code = TYPE_BYTE;
            CH_C:           r.code = TYPE_CHAR;
            CH_D:           r.code = TYPE_DOUBLE;
            CH_F:           r.code = TYPE_FLOAT;
            CH_I:           r.code = TYPE_INT;
            CH_J:           r.code = TYPE_LONG;
            CH_L, CH_LBRACK: r.code = TYPE_REF;
            CH_S:           r.code = TYPE_SHORT;
            CH_Z:           r.code = TYPE_BOOLEAN;
            CH_V:           r.code = TYPE_VOID;
            default:
            begin
                r.known = 1'b0;
                r.code  = TYPE_VOID;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: design/mdp_chan_if.sv
// Character input channel
interface mdp_in_if;
    logic               valid;
    logic               ready;
    mdp_pkg::mdp_in_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Parse result channel
interface mdp_out_if;
    logic               valid;
    logic               ready;
    mdp_pkg::mdp_out_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/method_descriptor_parser.sv
// Streaming type-descriptor parser. Feed one character per word on the input
// channel; a zero byte ends the descriptor, reports the final count, type and
// status with done_res set, and clears the parser for the next descriptor.
// Every input word yields exactly one result word, in order. A character is
// taken in every cycle while the result channel keeps up: the parse state and
// the single output register are updated in the same cycle, so throughput is
// one word per clock, each result showing in the next cycle; the input stalls
// only while a result waits in the output register and the sink is not ready.
module method_descriptor_parser (
    input  logic        clk,
    input  logic        rst_n,
    mdp_in_if.sink      in,
    mdp_out_if.source   out
);

    typedef enum logic [2:0] {
        PH_START,
        PH_PARAM,
        PH_ARRAY,
        PH_CLASS,
        PH_RET,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         count_reg, count_next;
    logic [3:0]         type_reg, type_next;
    logic [1:0]         err_reg, err_next;
    logic               out_valid_reg;
    mdp_pkg::mdp_out_t  out_data_reg, res_next;
    logic               in_fire;
    logic [7:0]         c;
    mdp_pkg::ret_decode_t dec;

    assign in.ready  = !out_valid_reg || out.ready;
    assign in_fire   = in.valid && in.ready;
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    assign c   = in.data.ch;
    assign dec = mdp_pkg::decode_type(c);

    // Advance the parse state and build the result word
    always_comb
    begin
        logic       sv;
        logic [7:0] sc;
        logic       rv;
        logic       bump;
        phase_next = phase_reg;
        count_next = count_reg;
        type_next  = type_reg;
        err_next   = err_reg;
        sv   = 1'b0;
        sc   = mdp_pkg::CH_NUL;
        rv   = 1'b0;
        bump = 1'b0;

        if (c == mdp_pkg::CH_NUL)
        begin
            // Terminator: finish the status, report, then clear
            case (phase_reg)
                PH_START, PH_RET:
                begin
                    type_next = mdp_pkg::TYPE_VOID;
                    err_next  = mdp_pkg::ST_WARN;
                    rv        = 1'b1;
                end
                PH_PARAM:
                    err_next = mdp_pkg::ST_NOCLOSE;
                PH_ARRAY, PH_CLASS:
                    err_next = mdp_pkg::ST_UNTERM;
                default:
                    rv = 1'b1;
            endcase
            res_next.sig_valid = 1'b0;
            res_next.sig_char  = mdp_pkg::CH_NUL;
            res_next.arg_count = count_reg;
            res_next.ret_valid = rv;
            res_next.ret_type  = type_next;
            res_next.done_res  = 1'b1;
            res_next.status    = err_next;
            phase_next = PH_START;
            count_next = '0;
            type_next  = mdp_pkg::TYPE_VOID;
            err_next   = mdp_pkg::ST_OK;
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (c == mdp_pkg::CH_LPAREN)
                    begin
                        phase_next = PH_PARAM;
                    end
                    else
                    begin
                        type_next  = dec.code;
                        phase_next = PH_DONE;
                        if (!dec.known)
                        begin
                            err_next = mdp_pkg::ST_WARN;
                        end
                    end
                end
                PH_PARAM:
                begin
                    if (c == mdp_pkg::CH_RPAREN)
                    begin
                        phase_next = PH_RET;
                    end
                    else if (c == mdp_pkg::CH_LBRACK)
                    begin
                        phase_next = PH_ARRAY;
                    end
                    else if (c == mdp_pkg::CH_L)
                    begin
                        phase_next = PH_CLASS;
                    end
                    else
                    begin
                        sv   = 1'b1;
                        sc   = c;
                        bump = 1'b1;
                    end
                end
                PH_ARRAY:
                begin
                    if (c == mdp_pkg::CH_LBRACK)
                    begin
                        phase_next = PH_ARRAY;
                    end
                    else if (mdp_pkg::is_prim(c) || c == mdp_pkg::CH_SEMI)
                    begin
                        sv         = 1'b1;
                        sc         = mdp_pkg::CH_L;
                        bump       = 1'b1;
                        phase_next = PH_PARAM;
                    end
                    else
                    begin
                        phase_next = PH_CLASS;
                    end
                end
                PH_CLASS:
                begin
                    if (c == mdp_pkg::CH_SEMI)
                    begin
                        sv         = 1'b1;
                        sc         = mdp_pkg::CH_L;
                        bump       = 1'b1;
                        phase_next = PH_PARAM;
                    end
                end
                PH_RET:
                begin
                    type_next  = dec.code;
                    phase_next = PH_DONE;
                    if (!dec.known)
                    begin
                        err_next = mdp_pkg::ST_WARN;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase

            // Saturating parameter count
            if (bump && count_reg != mdp_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 8'd1;
            end

            res_next.sig_valid = sv;
            res_next.sig_char  = sc;
            res_next.arg_count = count_next;
            res_next.ret_valid = (phase_next == PH_DONE);
            res_next.ret_type  = type_next;
            res_next.done_res  = 1'b0;
            res_next.status    = err_next;
        end
    end

    // Hold parse state and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            count_reg     <= '0;
            type_reg      <= mdp_pkg::TYPE_VOID;
            err_reg       <= mdp_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                type_reg      <= type_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_next;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Every accepted word yields a result word in the next cycle
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out.valid)
        else $error("accepted word produced no result");

    // Terminator reports done and clears the parser
    a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in.data.ch == mdp_pkg::CH_NUL |=>
            out.data.done_res && phase_reg == PH_START && count_reg == '0
            && err_reg == mdp_pkg::ST_OK)
        else $error("terminator did not finish and clear the parse");

    // A reported parameter letter is never zero
    a_sig_char: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.data.sig_valid |-> out.data.sig_char != mdp_pkg::CH_NUL)
        else $error("parameter reported with empty letter");

    // Structural errors never come with a decoded type
    a_err_no_ret: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && (out.data.status == mdp_pkg::ST_NOCLOSE
            || out.data.status == mdp_pkg::ST_UNTERM) |->
            !out.data.ret_valid && out.data.done_res)
        else $error("structural error reported with a return type");

    // Parameters are reported only while the parameter list is open
    a_sig_in_params: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res_next.sig_valid |-> phase_next == PH_PARAM)
        else $error("parameter reported outside the parameter list");

endmodule

FILE: sim/tb_method_descriptor_parser.sv
`timescale 1ns / 1ps

module tb_method_descriptor_parser;

    localparam int CHAR_TARGET  = 1750;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 1200;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 60;

    typedef enum logic [2:0] {
        PH_START,
        PH_PARAM,
        PH_ARRAY,
        PH_CLASS,
        PH_RET,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_QUARTER,
        SINK_MOSTLY
    } sink_mode_t;

    logic clk;
    logic rst_n;
    int   cycle_count;

    mdp_in_if  in_ch ();
    mdp_out_if out_ch ();

    method_descriptor_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    // One-letter types that close an array parameter
    function automatic logic is_prim_letter(input logic [7:0] c);
        case (c)
            mdp_pkg::CH_B, mdp_pkg::CH_C, mdp_pkg::CH_D, mdp_pkg::CH_F,
            mdp_pkg::CH_I, mdp_pkg::CH_J, mdp_pkg::CH_S, mdp_pkg::CH_Z,
            mdp_pkg::CH_V: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Track descriptor parse state and hold the expected result words
    class descriptor_scoreboard;
        parse_phase_t       phase;
        logic [7:0]         params;
        logic [3:0]         ret_code;
        logic [1:0]         stat;
        mdp_pkg::mdp_out_t  expected_q[$];
        int                 errors;
        int                 words_seen;

        function new();
            clear();
            errors     = 0;
            words_seen = 0;
        endfunction

        function void clear();
            phase    = PH_START;
            params   = 8'd0;
            ret_code = mdp_pkg::TYPE_VOID;
            stat     = mdp_pkg::ST_OK;
        endfunction

        function void bump_params();
            if (params != mdp_pkg::COUNT_MAX)
                params = params + 8'd1;
        endfunction

        // Decode the return or field type and move to the ignoring phase
        function void take_return(input logic [7:0] c);
            case (c)
                mdp_pkg::CH_B: ret_code = mdp_pkg::TYPE_BYTE;
                mdp_pkg::CH_C: ret_code = mdp_pkg::TYPE_CHAR;
                mdp_pkg::CH_D: ret_code = mdp_pkg::TYPE_DOUBLE;
                mdp_pkg::CH_F: ret_code = mdp_pkg::TYPE_FLOAT;
                mdp_pkg::CH_I: ret_code = mdp_pkg::TYPE_INT;
                mdp_pkg::CH_J: ret_code = mdp_pkg::TYPE_LONG;
                mdp_pkg::CH_L, mdp_pkg::CH_LBRACK: ret_code = mdp_pkg::TYPE_REF;
                mdp_pkg::CH_S: ret_code = mdp_pkg::TYPE_SHORT;
                mdp_pkg::CH_Z: ret_code = mdp_pkg::TYPE_BOOLEAN;
                mdp_pkg::CH_V: ret_code = mdp_pkg::TYPE_VOID;
                default:
                begin
                    ret_code = mdp_pkg::TYPE_VOID;
                    stat     = mdp_pkg::ST_WARN;
                end
            endcase
            phase = PH_DONE;
        endfunction

        // Advance the parse state by one accepted character
        function void note_char(input logic [7:0] c);
            mdp_pkg::mdp_out_t w;
            w = '0;
            if (c == mdp_pkg::CH_NUL)
            begin
                case (phase)
                    PH_START, PH_RET:
                    begin
                        ret_code    = mdp_pkg::TYPE_VOID;
                        stat        = mdp_pkg::ST_WARN;
                        w.ret_valid = 1'b1;
                    end
                    PH_PARAM:           stat = mdp_pkg::ST_NOCLOSE;
                    PH_ARRAY, PH_CLASS: stat = mdp_pkg::ST_UNTERM;
                    default:            w.ret_valid = 1'b1;
                endcase
                w.arg_count = params;
                w.ret_type  = ret_code;
                w.done_res  = 1'b1;
                w.status    = stat;
                clear();
            end
            else
            begin
                case (phase)
                    PH_START:
                    begin
                        if (c == mdp_pkg::CH_LPAREN)
                            phase = PH_PARAM;
                        else
                            take_return(c);
                    end
                    PH_PARAM:
                    begin
                        if (c == mdp_pkg::CH_RPAREN)
                            phase = PH_RET;
                        else if (c == mdp_pkg::CH_LBRACK)
                            phase = PH_ARRAY;
                        else if (c == mdp_pkg::CH_L)
                            phase = PH_CLASS;
                        else
                        begin
                            w.sig_valid = 1'b1;
                            w.sig_char  = c;
                            bump_params();
                        end
                    end
                    PH_ARRAY:
                    begin
                        if (is_prim_letter(c) || c == mdp_pkg::CH_SEMI)
                        begin
                            w.sig_valid = 1'b1;
                            w.sig_char  = mdp_pkg::CH_L;
                            bump_params();
                            phase = PH_PARAM;
                        end
                        else if (c != mdp_pkg::CH_LBRACK)
                            phase = PH_CLASS;
                    end
                    PH_CLASS:
                    begin
                        if (c == mdp_pkg::CH_SEMI)
                        begin
                            w.sig_valid = 1'b1;
                            w.sig_char  = mdp_pkg::CH_L;
                            bump_params();
                            phase = PH_PARAM;
                        end
                    end
                    PH_RET:  take_return(c);
                    default: ;
                endcase
                w.ret_valid = (phase == PH_DONE);
                w.arg_count = params;
                w.ret_type  = ret_code;
                w.status    = stat;
            end
            expected_q.push_back(w);
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: word %0d: %s got %0h expected %0h",
                         $realtime, words_seen, what, got, want);
        endtask

        // Compare one result word with the oldest expectation
        task check_word(input mdp_pkg::mdp_out_t got);
            mdp_pkg::mdp_out_t want;
            words_seen++;
            if (expected_q.size() == 0)
            begin
                report("unexpected word", 32'(got), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.sig_valid !== want.sig_valid)
                report("sig_valid", 32'(got.sig_valid), 32'(want.sig_valid));
            if (got.sig_char !== want.sig_char)
                report("sig_char", 32'(got.sig_char), 32'(want.sig_char));
            if (got.arg_count !== want.arg_count)
                report("arg_count", 32'(got.arg_count), 32'(want.arg_count));
            if (got.ret_valid !== want.ret_valid)
                report("ret_valid", 32'(got.ret_valid), 32'(want.ret_valid));
            if (got.ret_type !== want.ret_type)
                report("ret_type", 32'(got.ret_type), 32'(want.ret_type));
            if (got.done_res !== want.done_res)
                report("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    descriptor_scoreboard sb;
    logic [7:0] char_stream[$];
    logic [7:0] desc_buf[$];

    // Character pickers for the random descriptors
    function automatic logic [7:0] pick_prim();
        case ($urandom_range(0, 8))
            0:       return mdp_pkg::CH_B;
            1:       return mdp_pkg::CH_C;
            2:       return mdp_pkg::CH_D;
            3:       return mdp_pkg::CH_F;
            4:       return mdp_pkg::CH_I;
            5:       return mdp_pkg::CH_J;
            6:       return mdp_pkg::CH_S;
            7:       return mdp_pkg::CH_Z;
            default: return mdp_pkg::CH_V;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == mdp_pkg::CH_SEMI);
        return c;
    endfunction

    function automatic logic [7:0] pick_other_param();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == mdp_pkg::CH_LBRACK || c == mdp_pkg::CH_L || c == mdp_pkg::CH_RPAREN);
        return c;
    endfunction

    // Any character outside the type table
    function automatic logic [7:0] pick_unknown_type();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_prim_letter(c) || c == mdp_pkg::CH_L || c == mdp_pkg::CH_LBRACK);
        return c;
    endfunction

    function automatic void add_class_tail();
        repeat ($urandom_range(0, 4))
            desc_buf.push_back(pick_name_char());
        desc_buf.push_back(mdp_pkg::CH_SEMI);
    endfunction

    function automatic void add_param();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 11);
        if (r < 5)
            desc_buf.push_back(pick_prim());
        else if (r < 6)
            desc_buf.push_back(pick_other_param());
        else if (r < 8)
        begin
            desc_buf.push_back(mdp_pkg::CH_L);
            add_class_tail();
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                desc_buf.push_back(mdp_pkg::CH_LBRACK);
            r = $urandom_range(0, 5);
            if (r < 3)
                desc_buf.push_back(pick_prim());
            else if (r < 4)
                desc_buf.push_back(mdp_pkg::CH_SEMI);
            else if (r < 5)
            begin
                desc_buf.push_back(mdp_pkg::CH_L);
                add_class_tail();
            end
            else
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (is_prim_letter(c) || c == mdp_pkg::CH_SEMI
                       || c == mdp_pkg::CH_LBRACK);
                desc_buf.push_back(c);
                add_class_tail();
            end
        end
    endfunction

    // Return or field type, with junk behind it now and then
    function automatic void add_type();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: desc_buf.push_back(pick_prim());
            6:
            begin
                desc_buf.push_back(mdp_pkg::CH_L);
                add_class_tail();
            end
            7:
            begin
                desc_buf.push_back(mdp_pkg::CH_LBRACK);
                desc_buf.push_back(pick_prim());
            end
            8: desc_buf.push_back(pick_unknown_type());
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                desc_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void add_method(input int nparams, input logic prims_only);
        desc_buf.push_back(mdp_pkg::CH_LPAREN);
        repeat (nparams)
        begin
            if (prims_only)
                desc_buf.push_back(pick_prim());
            else
                add_param();
        end
        if ($urandom_range(0, 11) != 0)
            desc_buf.push_back(mdp_pkg::CH_RPAREN);
        add_type();
    endfunction

    // Directed descriptors, then random ones until the target is reached
    function automatic void build_stimulus();
        string head;
        int kind;
        int desc_count;
        int keep;

        // empty descriptor
        char_stream.push_back(mdp_pkg::CH_NUL);
        // arrays, class name led by a primitive letter, unknown return
        head = "([[I[;LIx;)Q";
        foreach (head[i])
            char_stream.push_back(head[i]);
        char_stream.push_back(mdp_pkg::CH_NUL);
        // top character as a parameter, nothing after the close
        char_stream.push_back(mdp_pkg::CH_LPAREN);
        char_stream.push_back(8'hFF);
        char_stream.push_back(mdp_pkg::CH_RPAREN);
        char_stream.push_back(mdp_pkg::CH_NUL);
        // no close paren
        char_stream.push_back(mdp_pkg::CH_LPAREN);
        char_stream.push_back(mdp_pkg::CH_Z);
        char_stream.push_back(mdp_pkg::CH_NUL);
        // field type with trailing junk
        char_stream.push_back(mdp_pkg::CH_J);
        char_stream.push_back(8'h80);
        char_stream.push_back(mdp_pkg::CH_NUL);
        // end inside an array prefix
        char_stream.push_back(mdp_pkg::CH_LPAREN);
        char_stream.push_back(mdp_pkg::CH_LBRACK);
        char_stream.push_back(mdp_pkg::CH_NUL);

        desc_count = 0;
        while (char_stream.size() < CHAR_TARGET)
        begin
            desc_buf.delete();
            kind = $urandom_range(0, 99);
            if (desc_count == 3)
                add_method($urandom_range(256, 300), 1'b1);
            else if (kind < 12)
                add_type();
            else if (kind < 75)
                add_method($urandom_range(0, 6), 1'b0);
            else if (kind < 88)
            begin
                // cut a well-formed method short
                add_method($urandom_range(1, 5), 1'b0);
                keep = $urandom_range(1, desc_buf.size() - 1);
                while (desc_buf.size() > keep)
                    void'(desc_buf.pop_back());
            end
            else
                repeat ($urandom_range(1, 8))
                    desc_buf.push_back(8'($urandom_range(1, 255)));
            foreach (desc_buf[i])
                char_stream.push_back(desc_buf[i]);
            char_stream.push_back(mdp_pkg::CH_NUL);
            desc_count++;
        end
    endfunction

    // Clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("** method_descriptor_parser: FAILED **");
        $finish;
    end

    // Feed characters in bursts, note each accepted word, then drain
    initial
    begin : char_sender
        int next_idx;
        int chars_taken;
        int burst_left;
        int gap_left;

        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        sb = new();
        build_stimulus();
        next_idx    = 0;
        chars_taken = 0;
        burst_left  = $urandom_range(1, 20);
        gap_left    = 0;
        wait (rst_n === 1'b1);
        while (chars_taken < char_stream.size())
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_char(in_ch.data.ch);
                chars_taken++;
            end
            // hold the offered word until it is taken
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (next_idx < char_stream.size() && gap_left == 0)
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.data.ch <= char_stream[next_idx];
                    next_idx++;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(50, 200);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** method_descriptor_parser: PASSED **");
        else
            $display("** method_descriptor_parser: FAILED **");
        $finish;
    end

    // Take result words, stalling by mode, with one long hold-off
    initial
    begin : result_sink
        int rx_cycle;
        int mode_left;
        int hold_left;
        sink_mode_t mode;

        out_ch.ready = 1'b0;
        rx_cycle  = 0;
        mode_left = 0;
        hold_left = 0;
        mode      = SINK_OPEN;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.data);
            rx_cycle++;
            if (rx_cycle == HOLD_AT)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:    out_ch.ready <= 1'b1;
                    SINK_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_QUARTER: out_ch.ready <= (rx_cycle % 4 == 0);
                    default:      out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

endmodule
